@@ design/hbb_pkg.sv @@
// Shared types and constants for the horizontal box blur.
// Used by the top level, the serial divider and the port checker.
`default_nettype none

package hbb_pkg;

  // Sizing of the line and the window
  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_RADIUS   = 10;
  localparam int PIXEL_BITS   = 8;
  localparam int RAD_BITS     = 4;
  localparam int WIN_DEPTH    = 2 * MAX_RADIUS + 1;
  localparam int WIN_IDX_BITS = $clog2(WIN_DEPTH);
  localparam int SPAN_BITS    = $clog2(WIN_DEPTH + 1);
  localparam int COL_BITS     = $clog2(MAX_WIDTH);
  localparam int SUM_BITS     = $clog2(WIN_DEPTH * ((1 << PIXEL_BITS) - 1) + 1);
  localparam int DIV_CNT_BITS = $clog2(SUM_BITS);

  // One input item
  typedef struct packed {
    logic [PIXEL_BITS-1:0] pixel_in;
    logic                  row_end;
  } hbb_in_t;

  // One result item
  typedef struct packed {
    logic [PIXEL_BITS-1:0] blurred;
    logic [COL_BITS-1:0]   centre_column;
    logic                  last_of_row;
  } hbb_out_t;

  // Sequencer states of the top level
  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_OUT
  } hbb_state_t;

endpackage

`default_nettype wire

@@ design/hbb_div.sv @@
// Restoring divider: one quotient bit per cycle, dividend MSB first.
// Depends on hbb_pkg for the sum and span widths.
`default_nettype none

module hbb_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [hbb_pkg::SUM_BITS-1:0] dividend,
  input  wire logic [hbb_pkg::SPAN_BITS-1:0] divisor,
  output logic                              done,
  output logic [hbb_pkg::SUM_BITS-1:0]      quotient
);
  import hbb_pkg::*;

  logic                    busy_r;
  logic                    done_r;
  logic [DIV_CNT_BITS-1:0] cnt_r;
  logic [SPAN_BITS-1:0]    div_r;
  logic [SPAN_BITS-1:0]    rem_r;
  logic [SUM_BITS-1:0]     quo_r;

  logic [SPAN_BITS:0]      trial;
  logic                    fits;
  logic [SPAN_BITS:0]      diff;
  logic                    last_step;

  // Shift the next dividend bit into the partial remainder and try the subtract
  always_comb begin
    trial     = {rem_r, quo_r[SUM_BITS-1]};
    fits      = (trial >= {1'b0, div_r});
    diff      = trial - {1'b0, div_r};
    last_step = (cnt_r == DIV_CNT_BITS'(SUM_BITS - 1));
  end

  // Control: run SUM_BITS steps after start, flag the end in the cycle after the last step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && last_step;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (last_step) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Datapath: dividend bits leave at the top, quotient bits enter at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      div_r <= divisor;
      rem_r <= '0;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= fits ? diff[SPAN_BITS-1:0] : trial[SPAN_BITS-1:0];
      quo_r <= {quo_r[SUM_BITS-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

@@ design/horizontal_box_blur.sv @@
// Horizontal box blur over streamed greyscale rows.
// Depends on hbb_pkg and the serial divider hbb_div.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data): one pixel per item, in row
//   order, with row_end set on the last pixel of a row. A pixel at column
//   MAX_WIDTH-1 ends the row regardless of row_end.
//   Result channel (out_valid / out_stall / out_data): the truncated mean of
//   the 2*radius+1 pixel window, its centre column and a last-of-row flag.
//   Border columns closer than radius to a row edge give no result.
//   Config channel (cfg_valid / cfg_ready / cfg_data): radius, 1 to 10.
//   Other values are dropped. An accepted write restarts the current row.
// Sequence:
//   A pixel that gives no result is taken while the block stays idle. A pixel
//   that gives a result goes through the window update, then SUM_BITS (13)
//   steps in the one-bit-per-cycle divider, then a step each to collect the
//   quotient and load the output register.
//   in_stall stays high while the divider runs and while a finished result
//   waits for a stalled output register; a result already in the output
//   register does not block the next pixel.
// Reset: synchronous rst_n sets radius to 1, empties the row and the output.
`default_nettype none

module horizontal_box_blur (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire hbb_pkg::hbb_in_t              in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output hbb_pkg::hbb_out_t                  out_data,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [hbb_pkg::RAD_BITS-1:0]  cfg_data
);
  import hbb_pkg::*;

  hbb_state_t            state_r, state_nxt;
  logic [RAD_BITS-1:0]   radius_r;
  logic [SUM_BITS-1:0]   sum_r;
  logic [COL_BITS-1:0]   col_r;
  logic [PIXEL_BITS-1:0] win_r [WIN_DEPTH];
  logic [COL_BITS-1:0]   cen_r;
  logic                  last_r;
  logic                  out_valid_r;
  hbb_out_t              out_data_r;

  logic                    in_acc;
  logic                    cfg_acc;
  logic                    cfg_ok;
  logic [SPAN_BITS-1:0]    span;
  logic [WIN_IDX_BITS-1:0] leave_idx;
  logic [COL_BITS-1:0]     span_col;
  logic [COL_BITS-1:0]     two_r_col;
  logic                    row_done;
  logic                    emit;
  logic [PIXEL_BITS-1:0]   leaving;
  logic [SUM_BITS-1:0]     sum_nxt;
  logic                    out_free;
  logic                    div_start;
  logic                    div_done;
  logic [SUM_BITS-1:0]     quotient;

  // Handshakes and window arithmetic
  always_comb begin
    in_acc    = in_valid && !in_stall;
    cfg_acc   = cfg_valid && cfg_ready;
    cfg_ok    = (cfg_data >= RAD_BITS'(1)) && (cfg_data <= RAD_BITS'(MAX_RADIUS));
    span      = {radius_r, 1'b1};
    leave_idx = {radius_r, 1'b0};
    span_col  = {{(COL_BITS-SPAN_BITS){1'b0}}, span};
    two_r_col = {{(COL_BITS-WIN_IDX_BITS){1'b0}}, leave_idx};
    row_done  = in_data.row_end || (col_r >= COL_BITS'(MAX_WIDTH - 1));
    emit      = (col_r >= two_r_col);
    leaving   = (col_r >= span_col) ? win_r[leave_idx] : '0;
    sum_nxt   = sum_r + {{(SUM_BITS-PIXEL_BITS){1'b0}}, in_data.pixel_in}
                      - {{(SUM_BITS-PIXEL_BITS){1'b0}}, leaving};
    out_free  = !out_valid_r || !out_stall;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && emit) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs: config takes precedence over a pixel in the same cycle
  always_comb begin
    in_stall  = 1'b1;
    cfg_ready = 1'b0;
    div_start = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        cfg_ready = 1'b1;
        in_stall  = cfg_valid;
        div_start = in_acc && emit;
      end
      S_DIV: begin
        in_stall = 1'b1;
      end
      S_OUT: begin
        in_stall = 1'b1;
      end
      default: in_stall = 1'b1;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      radius_r    <= RAD_BITS'(1);
      sum_r       <= '0;
      col_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_acc && cfg_ok) begin
        radius_r <= cfg_data;
        sum_r    <= '0;
        col_r    <= '0;
      end else if (in_acc) begin
        if (row_done) begin
          sum_r <= '0;
          col_r <= '0;
        end else begin
          sum_r <= sum_nxt;
          col_r <= col_r + 1'b1;
        end
      end
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Window shift line and per-item tags
  always_ff @(posedge clk) begin
    if (in_acc) begin
      win_r[0] <= in_data.pixel_in;
      for (int i = 1; i < WIN_DEPTH; i++) begin
        win_r[i] <= win_r[i-1];
      end
      cen_r  <= col_r - {{(COL_BITS-RAD_BITS){1'b0}}, radius_r};
      last_r <= row_done;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (state_r == S_OUT && out_free) begin
      out_data_r.blurred       <= quotient[PIXEL_BITS-1:0];
      out_data_r.centre_column <= cen_r;
      out_data_r.last_of_row   <= last_r;
    end
  end

  // Mean of the window: sum divided by the span, one bit a cycle
  hbb_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_nxt),
    .divisor  (span),
    .done     (div_done),
    .quotient (quotient)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

@@ design/hbb_chk.sv @@
// Port-level checker for the horizontal box blur, bound to the top level.
// Depends on hbb_pkg for the payload types.
`default_nettype none

module hbb_chk (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire hbb_pkg::hbb_out_t             out_data,
  input wire logic                          cfg_valid,
  input wire logic                          cfg_ready
);
  import hbb_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Reset empties the output register
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

  // A new result only comes out of a busy cycle
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without the block being busy");

  // A config write never coincides with an accepted pixel
  a_cfg_excl: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |-> !(in_valid && !in_stall))
    else $error("config write taken together with a pixel");

endmodule

bind horizontal_box_blur hbb_chk u_hbb_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);

`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// Testbench for horizontal_box_blur: directed and random pixel rows under several radii,
// checked against a line-window predictor. Depends on hbb_pkg and the design sources.
module tb;
  import hbb_pkg::*;

  localparam int QUIET_LIMIT   = 3000;
  localparam int SETTLE_CYCLES = 24;
  localparam int RANDOM_PHASES = 4;
  localparam int PHASE_ITEMS   = 24;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  hbb_in_t             in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  hbb_out_t            out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [RAD_BITS-1:0] cfg_data  = '0;

  horizontal_box_blur uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: radius, pixel window, running sum, next column
  logic [RAD_BITS-1:0]   model_radius = 4'd1;
  logic [PIXEL_BITS-1:0] line_win [WIN_DEPTH];
  logic [SUM_BITS-1:0]   win_sum = '0;
  logic [COL_BITS-1:0]   next_col = '0;

  hbb_out_t pending_means [$];
  hbb_in_t  pixel_queue [$];
  hbb_out_t mean_want;

  int   idle_pct     = 0;
  int   stall_pct    = 0;
  int   errors       = 0;
  int   quiet_cycles = 0;
  logic in_taken     = 1'b0;

  // Empty the window: next pixel starts a new row at column 0
  function automatic void clear_line();
    win_sum  = '0;
    next_col = '0;
  endfunction

  // Shift one pixel into the window and queue the mean it produces, if any
  task automatic blur_pixel(input hbb_in_t item);
    int       span;
    int       leaving;
    int       i;
    logic     row_done;
    hbb_out_t mean_item;
    span     = 2 * model_radius + 1;
    row_done = item.row_end || (next_col >= MAX_WIDTH - 1);
    leaving  = (next_col >= span) ? line_win[span - 1] : 0;
    for (i = WIN_DEPTH - 1; i > 0; i--) line_win[i] = line_win[i - 1];
    line_win[0] = item.pixel_in;
    win_sum = SUM_BITS'(win_sum + item.pixel_in - leaving);
    if (next_col + 1 >= span) begin
      mean_item.blurred       = PIXEL_BITS'(win_sum / span);
      mean_item.centre_column = next_col - model_radius;
      mean_item.last_of_row   = row_done;
      pending_means.push_back(mean_item);
    end
    if (row_done) begin
      clear_line();
    end else begin
      next_col = next_col + 1'b1;
    end
  endtask

  // Driver: present pixels from the queue, hold while stalled, stall the output at random
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pixel_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
        in_data  <= pixel_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Monitor: check results, predict accepted pixels, track radius writes, watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      in_taken = in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        if (pending_means.size() == 0) begin
          $error("unexpected result: blurred %0d centre_column %0d last_of_row %0b",
                 out_data.blurred, out_data.centre_column, out_data.last_of_row);
          errors++;
        end else begin
          mean_want = pending_means.pop_front();
          if (out_data.blurred !== mean_want.blurred) begin
            $error("blurred: expected %0d, got %0d", mean_want.blurred, out_data.blurred);
            errors++;
          end
          if (out_data.centre_column !== mean_want.centre_column) begin
            $error("centre_column: expected %0d, got %0d",
                   mean_want.centre_column, out_data.centre_column);
            errors++;
          end
          if (out_data.last_of_row !== mean_want.last_of_row) begin
            $error("last_of_row: expected %0b, got %0b",
                   mean_want.last_of_row, out_data.last_of_row);
            errors++;
          end
        end
      end
      if (in_taken) blur_pixel(in_data);
      // Out-of-range radius writes are dropped
      if (cfg_valid && cfg_ready && cfg_data >= 1 && cfg_data <= MAX_RADIUS) begin
        model_radius = cfg_data;
        clear_line();
      end
      if (in_taken || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb failed");
        $finish;
      end
    end else begin
      in_taken = 1'b0;
    end
  end

  function automatic logic [PIXEL_BITS-1:0] rand_pixel();
    case ($urandom_range(7))
      0: rand_pixel = '0;
      1: rand_pixel = '1;
      default: rand_pixel = PIXEL_BITS'($urandom_range((1 << PIXEL_BITS) - 1));
    endcase
  endfunction

  task automatic push_pixel(input logic [PIXEL_BITS-1:0] pix, input logic last);
    hbb_in_t item;
    item.pixel_in = pix;
    item.row_end  = last;
    pixel_queue.push_back(item);
  endtask

  // Queue whole rows, mostly long enough to fill the window, some short
  task automatic fill_rows(input int count, input int rad);
    int len;
    int i;
    int sent;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(7) == 0) begin
        len = $urandom_range(1, 2 * rad);
      end else begin
        len = $urandom_range(2 * rad + 1, 2 * rad + 24);
      end
      for (i = 0; i < len; i++) push_pixel(rand_pixel(), i == len - 1);
      sent += len;
    end
  endtask

  // Hold until every pixel is sent and every mean has come, then let the block settle
  task automatic wait_idle();
    do @(posedge clk); while (pixel_queue.size() != 0 || in_valid || pending_means.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_radius(input int value);
    @(negedge clk);
    cfg_data  <= RAD_BITS'(value);
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int i;
    int p;
    int r;
    int part;
    for (i = 0; i < WIN_DEPTH; i++) line_win[i] = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, radius 1 from reset: one-pixel row, row of exactly 2r, full and zero pixels
    push_pixel(8'd255, 1'b1);
    push_pixel(8'd0, 1'b0);
    push_pixel(8'd255, 1'b1);
    push_pixel(8'd255, 1'b0);
    push_pixel(8'd255, 1'b0);
    push_pixel(8'd255, 1'b0);
    push_pixel(8'd0, 1'b1);
    // Leave a row open, then change radius mid-row
    push_pixel(8'd128, 1'b0);
    push_pixel(8'd64, 1'b0);
    wait_idle();
    write_radius(2);
    push_pixel(8'd0, 1'b0);
    push_pixel(8'd255, 1'b0);
    push_pixel(8'd0, 1'b0);
    push_pixel(8'd255, 1'b0);
    push_pixel(8'd128, 1'b1);
    wait_idle();
    // Out-of-range writes must leave radius at 2
    write_radius(0);
    write_radius(12);
    push_pixel(8'd1, 1'b0);
    push_pixel(8'd2, 1'b0);
    push_pixel(8'd3, 1'b0);
    push_pixel(8'd4, 1'b0);
    push_pixel(8'd5, 1'b1);
    wait_idle();

    // Overlong row: the last column ends it without row_end, then a short fresh row
    write_radius(1);
    for (i = 0; i < MAX_WIDTH; i++) push_pixel(rand_pixel(), 1'b0);
    for (i = 0; i < 4; i++) push_pixel(rand_pixel(), i == 3);
    wait_idle();

    // Random phases, each with its own idle pattern and radius
    for (p = 0; p < RANDOM_PHASES; p++) begin
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 68; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 68; end
        default: begin idle_pct = 34; stall_pct = 34; end
      endcase
      r = (p == 0) ? MAX_RADIUS : (p == 1) ? 1 : $urandom_range(1, MAX_RADIUS);
      if (p % 2 == 1) write_radius($urandom_range(1) ? 0 : $urandom_range(MAX_RADIUS + 1, 15));
      write_radius(r);
      // Full window of maximum pixels gives the largest sum
      if (r == MAX_RADIUS) begin
        for (i = 0; i < WIN_DEPTH; i++) push_pixel('1, i == WIN_DEPTH - 1);
      end
      fill_rows(PHASE_ITEMS / 2, r);
      // Stop mid-row and drain, then restart with a new radius
      part = $urandom_range(1, 2 * r + 4);
      for (i = 0; i < part; i++) push_pixel(rand_pixel(), 1'b0);
      wait_idle();
      r = $urandom_range(1, MAX_RADIUS);
      write_radius(r);
      fill_rows(PHASE_ITEMS / 2, r);
      wait_idle();
    end

    idle_pct  = 0;
    stall_pct = 0;
    wait_idle();
    repeat (40) @(posedge clk);
    if (pending_means.size() != 0) begin
      $error("%0d expected means never arrived", pending_means.size());
      errors++;
    end
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/hbb_pkg.sv
design/hbb_div.sv
design/horizontal_box_blur.sv
design/hbb_chk.sv
dv/tb.sv
